/* src/csd_pkg.sv */
package csd_pkg;

  localparam int unsigned IO_BITS = 48;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_EXCESS,
    OP_X2,
    OP_NB_ONE,
    OP_NB_X,
    OP_NB_ZERO,
    OP_MUL_XP,
    OP_E_ZERO,
    OP_E_DBL,
    OP_E_DBL2,
    OP_E_ADD_D2,
    OP_SUM_ME,
    OP_SUB_Q,
    OP_MUL_CN,
    OP_ACC,
    OP_ROTATE,
    OP_OUTPUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic first;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_free;
  } status_t;

endpackage

/* src/csd_mul.sv */
module csd_mul #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned WORD_BITS = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic signed [WORD_BITS-1:0] res_o,
  output logic                        ovf_o,
  output logic                        done_o
);

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned DIG = (W + 1) / 2;
  localparam int unsigned PW  = 4 * DIG;

  localparam logic [PW-1:0] RND_HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [PW-1:0] LIM_POS  = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [PW-1:0] LIM_NEG  = LIM_POS + {{(PW-1){1'b0}}, 1'b1};
  localparam logic [W-1:0]  W_MAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  W_MIN    = {1'b1, {(W-1){1'b0}}};

  logic            busy_q;
  logic [2:0]      step_q;
  logic            done_q;
  logic            neg_q;
  logic [W-1:0]    ma_q;
  logic [W-1:0]    mb_q;
  logic [2*DIG-1:0] pp_q;
  logic [1:0]      sh_q;
  logic [PW-1:0]   acc_q;
  logic [PW-1:0]   rnd_q;
  logic [W-1:0]    res_q;
  logic            ovf_q;

  logic [W-1:0]     a_u;
  logic [W-1:0]     b_u;
  logic [W-1:0]     ma_d;
  logic [W-1:0]     mb_d;
  logic [2*DIG-1:0] ma_x;
  logic [2*DIG-1:0] mb_x;
  logic [DIG-1:0]   a_dig;
  logic [DIG-1:0]   b_dig;
  logic [2*DIG-1:0] pp_d;
  logic [1:0]       sh_d;
  logic [PW-1:0]    pp_shifted;
  logic [PW-1:0]    rnd_d;
  logic [PW-1:0]    lim;
  logic [W-1:0]     mag;
  logic [W-1:0]     res_d;
  logic             ovf_d;

  assign a_u  = a_i;
  assign b_u  = b_i;
  assign ma_d = a_u[W-1] ? (~a_u + {{(W-1){1'b0}}, 1'b1}) : a_u;
  assign mb_d = b_u[W-1] ? (~b_u + {{(W-1){1'b0}}, 1'b1}) : b_u;

  assign ma_x  = (2*DIG)'(ma_q);
  assign mb_x  = (2*DIG)'(mb_q);
  assign a_dig = step_q[0] ? ma_x[2*DIG-1:DIG] : ma_x[DIG-1:0];
  assign b_dig = step_q[1] ? mb_x[2*DIG-1:DIG] : mb_x[DIG-1:0];
  assign pp_d  = a_dig * b_dig;
  assign sh_d  = {1'b0, step_q[0]} + {1'b0, step_q[1]};

  always_comb begin
    case (sh_q)
      2'd0:    pp_shifted = PW'(pp_q);
      2'd1:    pp_shifted = PW'(pp_q) << DIG;
      2'd2:    pp_shifted = PW'(pp_q) << (2 * DIG);
      default: pp_shifted = '0;
    endcase
  end

  assign rnd_d = (acc_q + RND_HALF) >> FRAC_BITS;
  assign lim   = neg_q ? LIM_NEG : LIM_POS;
  assign mag   = rnd_q[W-1:0];

  always_comb begin
    if (rnd_q > lim) begin
      res_d = neg_q ? W_MIN : W_MAX;
      ovf_d = 1'b1;
    end else begin
      res_d = neg_q ? (~mag + {{(W-1){1'b0}}, 1'b1}) : mag;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
      done_q <= 1'b0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd6) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_u[W-1] ^ b_u[W-1];
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q < 3'd4) begin
        pp_q <= pp_d;
        sh_q <= sh_d;
      end
      if ((step_q >= 3'd1) && (step_q <= 3'd4)) begin
        acc_q <= acc_q + pp_shifted;
      end
      if (step_q == 3'd5) begin
        rnd_q <= rnd_d;
      end
      if (step_q == 3'd6) begin
        res_q <= res_d;
        ovf_q <= ovf_d;
      end
    end
  end

  assign res_o  = res_q;
  assign ovf_o  = ovf_q;
  assign done_o = done_q;

endmodule

/* src/csd_datapath.sv */
module csd_datapath #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned WORD_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csd_pkg::cmd_t                       cmd_i,
  output csd_pkg::status_t                    status_o,
  input  logic signed [csd_pkg::IO_BITS-1:0]  x_point_i,
  input  logic signed [csd_pkg::IO_BITS-1:0]  coefficient_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [csd_pkg::IO_BITS-1:0]  series_value_o,
  output logic signed [csd_pkg::IO_BITS-1:0]  first_derivative_o,
  output logic signed [csd_pkg::IO_BITS-1:0]  second_derivative_o,
  output logic signed [csd_pkg::IO_BITS-1:0]  third_derivative_o,
  output logic                                overflow_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned IO = csd_pkg::IO_BITS;
  localparam int unsigned XW = (W > IO) ? W : IO;

  localparam logic signed [W-1:0]  W_MAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  W_MIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [IO-1:0] IO_MAX   = {1'b0, {(IO-1){1'b1}}};
  localparam logic signed [IO-1:0] IO_MIN   = {1'b1, {(IO-1){1'b0}}};
  localparam logic signed [XW-1:0] W_MAX_X  = XW'(W_MAX);
  localparam logic signed [XW-1:0] W_MIN_X  = XW'(W_MIN);
  localparam logic signed [XW-1:0] IO_MAX_X = XW'(IO_MAX);
  localparam logic signed [XW-1:0] IO_MIN_X = XW'(IO_MIN);
  localparam logic                 ONE_SAT  = (FRAC_BITS >= WORD_BITS - 1);
  localparam logic signed [W-1:0]  ONE_VAL  = ONE_SAT ? W_MAX :
                                              ({{(W-1){1'b0}}, 1'b1} << FRAC_BITS);

  function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
                                         input logic signed [W-1:0] b,
                                         input logic                sub);
    logic [W:0] s;
    logic [W:0] r;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) begin
      r = {1'b1, (s[W] ? W_MIN : W_MAX)};
    end else begin
      r = {1'b0, s[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [W:0] in_clamp(input logic signed [IO-1:0] v);
    logic signed [XW-1:0] e;
    logic [W:0]           r;
    e = XW'(v);
    if (e > W_MAX_X) begin
      r = {1'b1, W_MAX};
    end else if (e < W_MIN_X) begin
      r = {1'b1, W_MIN};
    end else begin
      r = {1'b0, e[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [IO:0] out_clamp(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    logic [IO:0]          r;
    e = XW'(v);
    if (e > IO_MAX_X) begin
      r = {1'b1, IO_MAX};
    end else if (e < IO_MIN_X) begin
      r = {1'b1, IO_MIN};
    end else begin
      r = {1'b0, e[IO-1:0]};
    end
    return r;
  endfunction

  logic signed [W-1:0]  x_q;
  logic signed [W-1:0]  x2_q;
  logic signed [W-1:0]  c_q;
  logic signed [W-1:0]  nb_q;
  logic signed [W-1:0]  e_q;
  logic signed [W-1:0]  d2_q;
  logic signed [W-1:0]  prev_q;
  logic signed [W-1:0]  p_q [4];
  logic signed [W-1:0]  q_q [4];
  logic signed [W-1:0]  s_q [4];
  logic                 ovf_q;
  logic                 out_valid_q;
  logic signed [IO-1:0] out_val_q [4];
  logic                 out_ovf_q;

  logic signed [W-1:0] add_a;
  logic signed [W-1:0] add_b;
  logic                add_sub;
  logic [W:0]          add_r;
  logic [W:0]          x_in;
  logic [W:0]          c_in;
  logic [IO:0]         o_cl [4];
  logic                out_free;
  logic                mul_start;
  logic signed [W-1:0] mul_a;
  logic signed [W-1:0] mul_b;
  logic signed [W-1:0] mul_res;
  logic                mul_ovf;
  logic                mul_done;

  assign mul_start = (cmd_i.op == csd_pkg::OP_MUL_XP) || (cmd_i.op == csd_pkg::OP_MUL_CN);
  assign mul_a     = (cmd_i.op == csd_pkg::OP_MUL_CN) ? c_q  : x2_q;
  assign mul_b     = (cmd_i.op == csd_pkg::OP_MUL_CN) ? nb_q : p_q[0];

  csd_mul #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res),
    .ovf_o   (mul_ovf),
    .done_o  (mul_done)
  );

  always_comb begin
    add_a   = x_q;
    add_b   = x_q;
    add_sub = 1'b0;
    case (cmd_i.op)
      csd_pkg::OP_E_DBL: begin
        add_a = prev_q;
        add_b = prev_q;
      end
      csd_pkg::OP_E_DBL2: begin
        add_a = e_q;
        add_b = e_q;
      end
      csd_pkg::OP_E_ADD_D2: begin
        add_a = e_q;
        add_b = d2_q;
      end
      csd_pkg::OP_SUM_ME: begin
        add_a = mul_res;
        add_b = e_q;
      end
      csd_pkg::OP_SUB_Q: begin
        add_a   = nb_q;
        add_b   = q_q[0];
        add_sub = 1'b1;
      end
      csd_pkg::OP_ACC: begin
        add_a = s_q[0];
        add_b = mul_res;
      end
      default: begin
        add_a = x_q;
        add_b = x_q;
      end
    endcase
  end

  assign add_r = sat_add(add_a, add_b, add_sub);
  assign x_in  = in_clamp(x_point_i);
  assign c_in  = in_clamp(coefficient_i);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      o_cl[i] = out_clamp(s_q[i]);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        s_q[i] <= '0;
      end
    end else begin
      if (cmd_i.op == csd_pkg::OP_OUTPUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        csd_pkg::OP_CAPTURE: begin
          ovf_q <= ovf_q | c_in[W] | (cmd_i.first & x_in[W]);
        end
        csd_pkg::OP_EXCESS: begin
          ovf_q <= 1'b1;
        end
        csd_pkg::OP_NB_ONE: begin
          ovf_q <= ovf_q | ONE_SAT;
        end
        csd_pkg::OP_X2, csd_pkg::OP_E_DBL, csd_pkg::OP_E_DBL2, csd_pkg::OP_E_ADD_D2,
        csd_pkg::OP_SUB_Q: begin
          ovf_q <= ovf_q | add_r[W];
        end
        csd_pkg::OP_SUM_ME: begin
          ovf_q <= ovf_q | add_r[W] | mul_ovf;
        end
        csd_pkg::OP_ACC: begin
          ovf_q  <= ovf_q | add_r[W] | mul_ovf;
          s_q[0] <= add_r[W-1:0];
        end
        csd_pkg::OP_ROTATE: begin
          for (int i = 0; i < 3; i++) begin
            s_q[i] <= s_q[i+1];
          end
          s_q[3] <= s_q[0];
        end
        csd_pkg::OP_OUTPUT: begin
          ovf_q <= 1'b0;
          for (int i = 0; i < 4; i++) begin
            s_q[i] <= '0;
          end
        end
        default: begin
          ovf_q <= ovf_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      csd_pkg::OP_CAPTURE: begin
        c_q <= c_in[W-1:0];
        if (cmd_i.first) begin
          x_q <= x_in[W-1:0];
        end
      end
      csd_pkg::OP_X2: begin
        x2_q <= add_r[W-1:0];
      end
      csd_pkg::OP_NB_ONE: begin
        nb_q <= ONE_VAL;
      end
      csd_pkg::OP_NB_X: begin
        nb_q <= x_q;
      end
      csd_pkg::OP_NB_ZERO: begin
        nb_q <= '0;
      end
      csd_pkg::OP_E_ZERO: begin
        e_q <= '0;
      end
      csd_pkg::OP_E_DBL: begin
        e_q  <= add_r[W-1:0];
        d2_q <= add_r[W-1:0];
      end
      csd_pkg::OP_E_DBL2, csd_pkg::OP_E_ADD_D2: begin
        e_q <= add_r[W-1:0];
      end
      csd_pkg::OP_SUM_ME, csd_pkg::OP_SUB_Q: begin
        nb_q <= add_r[W-1:0];
      end
      csd_pkg::OP_ROTATE: begin
        prev_q <= p_q[0];
        for (int i = 0; i < 3; i++) begin
          p_q[i] <= p_q[i+1];
          q_q[i] <= q_q[i+1];
        end
        p_q[3] <= nb_q;
        q_q[3] <= p_q[0];
      end
      csd_pkg::OP_OUTPUT: begin
        for (int i = 0; i < 4; i++) begin
          out_val_q[i] <= o_cl[i][IO-1:0];
        end
        out_ovf_q <= ovf_q | o_cl[0][IO] | o_cl[1][IO] | o_cl[2][IO] | o_cl[3][IO];
      end
      default: begin
        c_q <= c_q;
      end
    endcase
  end

  assign status_o.mul_done = mul_done;
  assign status_o.out_free = out_free;

  assign out_valid_o         = out_valid_q;
  assign series_value_o      = out_val_q[0];
  assign first_derivative_o  = out_val_q[1];
  assign second_derivative_o = out_val_q[2];
  assign third_derivative_o  = out_val_q[3];
  assign overflow_o          = out_ovf_q;

endmodule

/* src/csd_ctrl.sv */
module csd_ctrl #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             last_term_i,
  output csd_pkg::cmd_t    cmd_o,
  input  csd_pkg::status_t status_i
);

  localparam int unsigned IW = $clog2(MAX_TERMS + 1);

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_X2     = 15'h0002,
    S_INIT   = 15'h0004,
    S_LANE   = 15'h0008,
    S_EPREP  = 15'h0010,
    S_E4     = 15'h0020,
    S_E6     = 15'h0040,
    S_MWAIT1 = 15'h0080,
    S_SUM    = 15'h0100,
    S_SUB    = 15'h0200,
    S_MULC   = 15'h0400,
    S_MWAIT2 = 15'h0800,
    S_ACC    = 15'h1000,
    S_ROT    = 15'h2000,
    S_OUT    = 15'h4000
  } state_e;

  state_e        state_q, state_d;
  logic [1:0]    lane_q, lane_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          last_q, last_d;

  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    idx_d       = idx_q;
    last_d      = last_q;
    cmd_o.op    = csd_pkg::OP_NONE;
    cmd_o.first = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = last_term_i;
          lane_d = 2'd0;
          if (idx_q >= IW'(MAX_TERMS)) begin
            cmd_o.op = csd_pkg::OP_EXCESS;
            state_d  = last_term_i ? S_OUT : S_IDLE;
          end else begin
            cmd_o.op    = csd_pkg::OP_CAPTURE;
            cmd_o.first = (idx_q == IW'(0));
            state_d     = (idx_q < IW'(2)) ? S_INIT : S_X2;
          end
        end
      end
      S_X2: begin
        cmd_o.op = csd_pkg::OP_X2;
        state_d  = S_LANE;
      end
      S_INIT: begin
        if (idx_q == IW'(0)) begin
          cmd_o.op = (lane_q == 2'd0) ? csd_pkg::OP_NB_ONE : csd_pkg::OP_NB_ZERO;
        end else if (lane_q == 2'd0) begin
          cmd_o.op = csd_pkg::OP_NB_X;
        end else if (lane_q == 2'd1) begin
          cmd_o.op = csd_pkg::OP_NB_ONE;
        end else begin
          cmd_o.op = csd_pkg::OP_NB_ZERO;
        end
        state_d = S_MULC;
      end
      S_LANE: begin
        cmd_o.op = csd_pkg::OP_MUL_XP;
        state_d  = S_EPREP;
      end
      S_EPREP: begin
        if (lane_q == 2'd0) begin
          cmd_o.op = csd_pkg::OP_E_ZERO;
          state_d  = S_MWAIT1;
        end else begin
          cmd_o.op = csd_pkg::OP_E_DBL;
          state_d  = (lane_q == 2'd1) ? S_MWAIT1 : S_E4;
        end
      end
      S_E4: begin
        cmd_o.op = csd_pkg::OP_E_DBL2;
        state_d  = (lane_q == 2'd3) ? S_E6 : S_MWAIT1;
      end
      S_E6: begin
        cmd_o.op = csd_pkg::OP_E_ADD_D2;
        state_d  = S_MWAIT1;
      end
      S_MWAIT1: begin
        if (status_i.mul_done) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.op = csd_pkg::OP_SUM_ME;
        state_d  = S_SUB;
      end
      S_SUB: begin
        cmd_o.op = csd_pkg::OP_SUB_Q;
        state_d  = S_MULC;
      end
      S_MULC: begin
        cmd_o.op = csd_pkg::OP_MUL_CN;
        state_d  = S_MWAIT2;
      end
      S_MWAIT2: begin
        if (status_i.mul_done) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.op = csd_pkg::OP_ACC;
        state_d  = S_ROT;
      end
      S_ROT: begin
        cmd_o.op = csd_pkg::OP_ROTATE;
        lane_d   = lane_q + 2'd1;
        if (lane_q == 2'd3) begin
          idx_d   = idx_q + IW'(1);
          state_d = last_q ? S_OUT : S_IDLE;
        end else begin
          state_d = (idx_q >= IW'(2)) ? S_LANE : S_INIT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = csd_pkg::OP_OUTPUT;
          idx_d    = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lane_q  <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* src/chebyshev_series_with_derivatives.sv */
// Channel  Handshake                  Payload
// in       in_valid_i / in_stall_o    x_point_i, coefficient_i, last_term_i
// out      out_valid_o / out_stall_i  the four *_derivative_o / series_value_o sums, overflow_o
//
// One item is worked on at a time; its length is set by the shared multiplier, which
// is used once per basis lane for the first two terms of a run and twice per lane for
// every later term, over four lanes. A term beyond MAX_TERMS is dropped and sets the
// overflow flag; the last item also loads the result into the output register.
// Reset clears the run state and the output valid flag, and the block is ready at once.
// A stalled result stays in the output register while the next run is computed.
module chebyshev_series_with_derivatives #(
  parameter int unsigned MAX_TERMS = 16,
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned WORD_BITS = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [csd_pkg::IO_BITS-1:0] x_point_i,
  input  logic signed [csd_pkg::IO_BITS-1:0] coefficient_i,
  input  logic                               last_term_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [csd_pkg::IO_BITS-1:0] series_value_o,
  output logic signed [csd_pkg::IO_BITS-1:0] first_derivative_o,
  output logic signed [csd_pkg::IO_BITS-1:0] second_derivative_o,
  output logic signed [csd_pkg::IO_BITS-1:0] third_derivative_o,
  output logic                               overflow_o
);

  csd_pkg::cmd_t    cmd;
  csd_pkg::status_t status;

  csd_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_term_i (last_term_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  csd_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .x_point_i           (x_point_i),
    .coefficient_i       (coefficient_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .series_value_o      (series_value_o),
    .first_derivative_o  (first_derivative_o),
    .second_derivative_o (second_derivative_o),
    .third_derivative_o  (third_derivative_o),
    .overflow_o          (overflow_o)
  );

endmodule

/* bench/chebyshev_series_with_derivatives_tb.sv */
`timescale 1ns / 100ps

module chebyshev_series_with_derivatives_tb;

  localparam int unsigned IO_BITS = csd_pkg::IO_BITS;
  localparam int unsigned MAX_TERMS = 16;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned WORD_BITS = 48;
  localparam int unsigned ITEM_TOTAL = 1800;
  localparam int unsigned CALM_FROM = 1600;
  localparam int unsigned HOLD_AT = 500;
  localparam int unsigned DRAIN_AT = 1100;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES = 200;

  typedef logic signed [63:0] word_t;
  typedef logic [IO_BITS-1:0] io_t;

  localparam word_t W_MAX = (word_t'(1) <<< (WORD_BITS - 1)) - 1;
  localparam word_t W_MIN = -W_MAX - 1;
  localparam word_t IO_MAX = (word_t'(1) <<< (IO_BITS - 1)) - 1;
  localparam word_t IO_MIN = -IO_MAX - 1;
  localparam word_t ONE_Q = word_t'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic [3:0][IO_BITS-1:0] sums;
    logic                    ovf;
  } series_result_t;

  typedef enum int {
    RUN_TAME,
    RUN_WILD,
    RUN_EDGE
  } run_kind_e;

  class series_scoreboard;
    word_t          held_x;
    word_t          basis[8];
    word_t          sums[4];
    bit             ovf;
    int unsigned    terms;
    series_result_t expected_q[$];
    int unsigned    mismatches;
    int unsigned    checked;
    int unsigned    flagged;

    function new();
      clear();
      mismatches = 0;
      checked = 0;
      flagged = 0;
    endfunction

    function void clear();
      terms = 0;
      held_x = 0;
      ovf = 1'b0;
      for (int i = 0; i < 8; i++) basis[i] = 0;
      for (int i = 0; i < 4; i++) sums[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function word_t clamp(word_t v, word_t lo, word_t hi);
      if (v > hi) begin
        ovf = 1'b1;
        return hi;
      end
      if (v < lo) begin
        ovf = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function word_t sat65(logic signed [64:0] s);
      if (s > 65'(W_MAX)) begin
        ovf = 1'b1;
        return W_MAX;
      end
      if (s < 65'(W_MIN)) begin
        ovf = 1'b1;
        return W_MIN;
      end
      return s[63:0];
    endfunction

    function word_t add_sat(word_t a, word_t b);
      return sat65(65'(a) + 65'(b));
    endfunction

    function word_t sub_sat(word_t a, word_t b);
      return sat65(65'(a) - 65'(b));
    endfunction

    function word_t mul_sat(word_t a, word_t b);
      logic signed [127:0] aw;
      logic signed [127:0] bw;
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] q;
      logic [127:0] lim;
      word_t r;
      bit neg;
      neg = a[63] ^ b[63];
      aw = a;
      bw = b;
      ma = aw[127] ? -aw : aw;
      mb = bw[127] ? -bw : bw;
      q = (ma * mb + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      lim = neg ? 128'(W_MAX) + 128'd1 : 128'(W_MAX);
      if (q > lim) begin
        ovf = 1'b1;
        return neg ? W_MIN : W_MAX;
      end
      r = q[63:0];
      return neg ? -r : r;
    endfunction

    function word_t unit_value();
      if ((128'd1 << FRAC_BITS) > 128'(W_MAX)) begin
        ovf = 1'b1;
        return W_MAX;
      end
      return ONE_Q;
    endfunction

    function word_t from_io(io_t v);
      word_t s;
      s = word_t'($signed(v));
      return clamp(s, W_MIN, W_MAX);
    endfunction

    function void note_input(io_t x_in, io_t c_in, logic last);
      word_t c;
      word_t x2;
      word_t d1x2;
      word_t d1x4;
      word_t d2x2;
      word_t d2x4;
      word_t d2x6;
      word_t tmp;
      word_t nb[4];
      series_result_t r;
      if (terms == 0) held_x = from_io(x_in);
      if (terms >= MAX_TERMS) begin
        ovf = 1'b1;
      end else begin
        c = from_io(c_in);
        if (terms == 0) begin
          nb[0] = unit_value();
          nb[1] = 0;
          nb[2] = 0;
          nb[3] = 0;
        end else if (terms == 1) begin
          nb[0] = held_x;
          nb[1] = unit_value();
          nb[2] = 0;
          nb[3] = 0;
        end else begin
          x2 = add_sat(held_x, held_x);
          d1x2 = add_sat(basis[1], basis[1]);
          d1x4 = add_sat(d1x2, d1x2);
          d2x2 = add_sat(basis[2], basis[2]);
          d2x4 = add_sat(d2x2, d2x2);
          d2x6 = add_sat(d2x4, d2x2);
          nb[0] = sub_sat(mul_sat(x2, basis[0]), basis[4]);
          nb[1] = sub_sat(add_sat(add_sat(basis[0], basis[0]), mul_sat(x2, basis[1])),
                          basis[5]);
          nb[2] = sub_sat(add_sat(mul_sat(x2, basis[2]), d1x4), basis[6]);
          nb[3] = sub_sat(add_sat(mul_sat(x2, basis[3]), d2x6), basis[7]);
        end
        for (int i = 0; i < 4; i++) begin
          sums[i] = add_sat(sums[i], mul_sat(c, nb[i]));
          basis[4 + i] = basis[i];
          basis[i] = nb[i];
        end
        terms++;
      end
      if (last) begin
        for (int i = 0; i < 4; i++) begin
          tmp = clamp(sums[i], IO_MIN, IO_MAX);
          r.sums[i] = tmp[IO_BITS-1:0];
        end
        r.ovf = ovf;
        if (ovf) flagged++;
        expected_q.push_back(r);
        clear();
      end
    endfunction

    function void check_result(logic [3:0][IO_BITS-1:0] got, logic got_ovf);
      series_result_t e;
      string names[4];
      names = '{"series_value", "first_derivative", "second_derivative",
                "third_derivative"};
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, expected none, got series_value %h",
                 $time, got[0]);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      for (int i = 0; i < 4; i++) begin
        if (got[i] !== e.sums[i]) begin
          mismatches++;
          $display("%0t: %s mismatch, expected %h, got %h", $time, names[i], e.sums[i],
                   got[i]);
        end
      end
      if (got_ovf !== e.ovf) begin
        mismatches++;
        $display("%0t: overflow mismatch, expected %b, got %b", $time, e.ovf, got_ovf);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  io_t  x_point;
  io_t  coefficient;
  logic last_term;
  logic out_valid;
  logic out_stall;
  io_t  series_value;
  io_t  first_derivative;
  io_t  second_derivative;
  io_t  third_derivative;
  logic overflow;

  series_scoreboard sb = new();

  bit          calm;
  bit          long_hold_req;
  bit          long_hold_done;
  bit          drain_done;
  int unsigned stall_left;
  int unsigned n_items;
  int unsigned n_runs;
  int unsigned n_long_runs;

  chebyshev_series_with_derivatives #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .x_point_i           (x_point),
    .coefficient_i       (coefficient),
    .last_term_i         (last_term),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .series_value_o      (series_value),
    .first_derivative_o  (first_derivative),
    .second_derivative_o (second_derivative),
    .third_derivative_o  (third_derivative),
    .overflow_o          (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({third_derivative, second_derivative, first_derivative, series_value},
                      overflow);
    end
  end

  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (calm) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic io_t full_random();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[IO_BITS-1:0];
  endfunction

  function automatic io_t edge_value();
    word_t v;
    case ($urandom_range(0, 7))
      0: v = IO_MAX;
      1: v = IO_MIN;
      2: v = 0;
      3: v = ONE_Q;
      4: v = -ONE_Q;
      5: v = 1;
      6: v = -1;
      default: v = word_t'($signed(full_random()));
    endcase
    return v[IO_BITS-1:0];
  endfunction

  function automatic io_t bounded_value(int unsigned span);
    word_t v;
    v = word_t'($urandom_range(0, 2 * span)) - word_t'(span);
    return v[IO_BITS-1:0];
  endfunction

  function automatic io_t pick_point(run_kind_e kind);
    case (kind)
      RUN_TAME: return bounded_value($urandom_range(0, 4) == 0 ? 1 << 25 : 1 << 24);
      RUN_WILD: return full_random();
      default: return edge_value();
    endcase
  endfunction

  function automatic io_t pick_coef(run_kind_e kind);
    case (kind)
      RUN_TAME: return bounded_value(1 << 26);
      RUN_WILD: return full_random();
      default: return $urandom_range(0, 1) ? edge_value() : full_random();
    endcase
  endfunction

  task automatic send_item(io_t x, io_t c, logic last);
    @(negedge clk);
    in_valid <= 1'b1;
    x_point <= x;
    coefficient <= c;
    last_term <= last;
    do @(posedge clk); while (in_stall);
    sb.note_input(x, c, last);
    n_items++;
  endtask

  task automatic idle_for(int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_run(run_kind_e kind, int unsigned len);
    io_t x;
    x = pick_point(kind);
    for (int unsigned k = 0; k < len; k++) begin
      send_item(k == 0 ? x : full_random(), pick_coef(kind), k == len - 1);
      if (!calm && $urandom_range(0, 4) == 0) idle_for($urandom_range(1, 4));
    end
    n_runs++;
    if (len > MAX_TERMS) n_long_runs++;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    run_kind_e   kind;
    int unsigned len;
    int unsigned pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    x_point = '0;
    coefficient = '0;
    last_term = 1'b0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    drain_done = 1'b0;
    n_items = 0;
    n_runs = 0;
    n_long_runs = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-term runs at both coefficient extremes.
    send_item(IO_MAX[IO_BITS-1:0], IO_MAX[IO_BITS-1:0], 1'b1);
    send_item(IO_MIN[IO_BITS-1:0], IO_MIN[IO_BITS-1:0], 1'b1);
    n_runs += 2;
    // Extreme point and coefficients drive the three lower lanes into saturation.
    send_item(IO_MAX[IO_BITS-1:0], IO_MAX[IO_BITS-1:0], 1'b0);
    send_item(IO_MIN[IO_BITS-1:0], IO_MIN[IO_BITS-1:0], 1'b0);
    send_item(io_t'(0), IO_MAX[IO_BITS-1:0], 1'b1);
    n_runs++;
    // A run longer than the term limit, with the last mark on a dropped term.
    for (int unsigned k = 0; k < MAX_TERMS + 2; k++) begin
      send_item(io_t'(ONE_Q >>> 1), io_t'(ONE_Q >>> 4), k == MAX_TERMS + 1);
    end
    n_runs++;
    n_long_runs++;

    while (n_items < ITEM_TOTAL) begin
      pick = $urandom_range(0, 9);
      kind = pick < 6 ? RUN_TAME : (pick < 8 ? RUN_WILD : RUN_EDGE);
      pick = $urandom_range(0, 9);
      len = pick < 8 ? $urandom_range(1, MAX_TERMS) :
            (pick == 8 ? $urandom_range(MAX_TERMS + 1, MAX_TERMS + 6) : $urandom_range(1, 3));
      calm = (n_items >= CALM_FROM) || ($urandom_range(0, 6) == 0);
      if (!long_hold_done && n_items >= HOLD_AT) begin
        long_hold_done = 1'b1;
        long_hold_req = 1'b1;
      end
      if (!drain_done && n_items >= DRAIN_AT) begin
        drain_done = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
      end
      send_run(kind, len);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d coefficients in %0d runs, %0d of them past the term limit.",
             n_items, n_runs, n_long_runs);
    $display("Checked %0d results, %0d with the overflow flag set.", sb.checked, sb.flagged);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
